FILE: rtl/rmf_pkg.sv
package rmf_pkg;

  localparam int CoordFracBits = 16;
  // right shifts that bring the squared lengths to Q16.16
  localparam int ChordShift    = CoordFracBits - 2;
  localparam int TdiffShift    = 58 - CoordFracBits;

  localparam logic [1:0] RegStartNx = 2'd0;
  localparam logic [1:0] RegStartNy = 2'd1;
  localparam logic [1:0] RegStartNz = 2'd2;
  localparam logic [1:0] RegMinSq   = 2'd3;

  localparam logic [31:0] StartNzReset = 32'h4000_0000;
  localparam logic [31:0] MinSqReset   = 32'd1;

  typedef struct packed {
    logic               first_sample;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] deriv_x;
    logic signed [31:0] deriv_y;
    logic signed [31:0] deriv_z;
    logic [30:0]        arc_step;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic [31:0]        arc_total;
    logic               degenerate;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] wdata;
  } cfg_req_t;

  typedef enum logic [3:0] {
    OP_NORM,
    OP_SET_T,
    OP_FIRST,
    OP_CHORD,
    OP_SQ_CHORD,
    OP_SQ_TDIFF,
    OP_DEGEN,
    OP_REFL_N,
    OP_REFL_T,
    OP_REFL_2,
    OP_TDIFF,
    OP_COPY_NL,
    OP_COMMIT,
    OP_OUT
  } op_e;

  typedef struct packed {
    logic load;
    logic go;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic first;
    logic below_min;
  } sts_t;

endpackage

FILE: rtl/rmf_if.sv
interface rmf_in_if;
  logic               valid;
  logic               ready;
  rmf_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rmf_out_if;
  logic               valid;
  logic               ready;
  rmf_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rmf_cfg_if;
  logic               valid;
  logic               ready;
  rmf_pkg::cfg_req_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/rmf_dp.sv
module rmf_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rmf_pkg::cmd_t      cmd_i,
  output rmf_pkg::sts_t      sts_o,
  input  rmf_pkg::in_item_t  in_data_i,
  input  logic               cfg_we_i,
  input  rmf_pkg::cfg_req_t  cfg_req_i,
  output rmf_pkg::out_item_t out_data_o
);

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_MAG   = 4'd1;
  localparam logic [3:0] PH_SHIFT = 4'd2;
  localparam logic [3:0] PH_SQ    = 4'd3;
  localparam logic [3:0] PH_SQRT  = 4'd4;
  localparam logic [3:0] PH_DINIT = 4'd5;
  localparam logic [3:0] PH_DIV   = 4'd6;
  localparam logic [3:0] PH_SQL   = 4'd7;
  localparam logic [3:0] PH_DOT   = 4'd8;
  localparam logic [3:0] PH_RFL   = 4'd9;

  // control and architectural state
  logic [3:0]         phase_q, phase_d;
  logic               done_q, done_d;
  logic               first_q, first_d;
  logic               below_q, below_d;
  logic               degen_q, degen_d;
  logic [31:0]        arc_q, arc_d;
  logic [1:0]         idx_q, idx_d;
  logic               half_q, half_d;
  logic [4:0]         cnt_q, cnt_d;
  rmf_pkg::op_e       op_q, op_d;
  logic signed [31:0] ppt_q [3], ppt_d [3];
  logic signed [31:0] ptan_q [3], ptan_d [3];
  logic signed [31:0] pnrm_q [3], pnrm_d [3];
  logic signed [31:0] sn_q [3], sn_d [3];
  logic [31:0]        min_q, min_d;

  // working registers
  logic signed [31:0] pt_q [3], pt_d [3];
  logic [30:0]        step_q, step_d;
  logic signed [34:0] vec_q [3], vec_d [3];
  logic [34:0]        m_q [3], m_d [3];
  logic signed [31:0] unit_q [3], unit_d [3];
  logic signed [31:0] t_q [3], t_d [3];
  logic signed [31:0] nl_q [3], nl_d [3];
  logic signed [31:0] dl_q [3], dl_d [3];
  logic [63:0]        acc_q, acc_d;
  logic [63:0]        sx_q, sx_d;
  logic [63:0]        r_q, r_d;
  logic [31:0]        len_q, len_d;
  logic [32:0]        rem_q, rem_d;
  logic [31:0]        dn_q, dn_d;
  logic [31:0]        qt_q, qt_d;
  logic signed [34:0] p_q, p_d;
  logic signed [69:0] prod_q, prod_d;
  rmf_pkg::out_item_t out_q, out_d;

  // helpers
  logic [34:0]        mx;
  logic signed [34:0] mul_a, mul_b;
  logic signed [31:0] xs [3];
  logic [63:0]        acc_sum, sq_sh, bit_v, trial, r_nx, dmag, dround;
  logic [33:0]        pm;
  logic signed [34:0] p_v;
  logic [69:0]        pmag, psum;
  logic [40:0]        tm;
  logic signed [41:0] term, rwide;
  logic signed [31:0] rsat;
  logic [32:0]        rem_sh, arc_sum;
  logic               q_bit;
  logic [31:0]        qfin;
  logic [61:0]        num;

  always_comb begin
    mx = m_q[0];
    if (m_q[1] > mx) mx = m_q[1];
    if (m_q[2] > mx) mx = m_q[2];

    for (int i = 0; i < 3; i++) begin
      case (op_q)
        rmf_pkg::OP_REFL_N: xs[i] = pnrm_q[i];
        rmf_pkg::OP_REFL_T: xs[i] = ptan_q[i];
        default:            xs[i] = nl_q[i];
      endcase
    end

    case (phase_q)
      PH_SQ: begin
        mul_a = $signed(m_q[idx_q]);
        mul_b = $signed(m_q[idx_q]);
      end
      PH_SQL: begin
        mul_a = vec_q[idx_q];
        mul_b = vec_q[idx_q];
      end
      PH_DOT: begin
        mul_a = 35'(unit_q[idx_q]);
        mul_b = 35'(xs[idx_q]);
      end
      PH_RFL: begin
        mul_a = 35'(unit_q[idx_q]);
        mul_b = p_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    case (phase_q)
      PH_SQL:  acc_sum = acc_q + {2'b00, prod_q[63:2]};
      default: acc_sum = acc_q + prod_q[63:0];
    endcase
    sq_sh = (op_q == rmf_pkg::OP_SQ_CHORD) ? (acc_sum >> rmf_pkg::ChordShift)
                                           : (acc_sum >> rmf_pkg::TdiffShift);

    // one square-root digit per cycle
    bit_v = 64'd1 << (6'd62 - {cnt_q, 1'b0});
    trial = r_q + bit_v;
    r_nx  = (sx_q >= trial) ? ((r_q >> 1) + bit_v) : (r_q >> 1);

    // one quotient bit per cycle
    rem_sh = {rem_q[31:0], dn_q[31]};
    q_bit  = (rem_sh >= {1'b0, len_q});
    qfin   = {qt_q[30:0], q_bit};
    num    = 62'({m_q[idx_q][30:0], 30'd0}) + 62'(len_q[31:1]);

    // dot product rounded to Q2.30 projection
    dmag   = acc_sum[63] ? (~acc_sum + 64'd1) : acc_sum;
    dround = dmag + 64'h0000_0000_2000_0000;
    pm     = dround[63:30];
    p_v    = acc_sum[63] ? -$signed({1'b0, pm}) : $signed({1'b0, pm});

    pmag  = prod_q[69] ? (~prod_q + 70'd1) : prod_q;
    psum  = pmag + 70'h0_0000_0000_1000_0000;
    tm    = psum[69:29];
    term  = prod_q[69] ? -$signed({1'b0, tm}) : $signed({1'b0, tm});
    rwide = 42'(xs[idx_q]) - term;
    if (rwide > 42'sd2147483647) rsat = 32'sh7fff_ffff;
    else if (rwide < -42'sd2147483648) rsat = 32'sh8000_0000;
    else rsat = rwide[31:0];

    arc_sum = {1'b0, arc_q} + 33'(step_q);
  end

  always_comb begin
    phase_d = phase_q;
    done_d  = 1'b0;
    first_d = first_q;
    below_d = below_q;
    degen_d = degen_q;
    arc_d   = arc_q;
    idx_d   = idx_q;
    half_d  = half_q;
    cnt_d   = cnt_q;
    op_d    = op_q;
    ppt_d   = ppt_q;
    ptan_d  = ptan_q;
    pnrm_d  = pnrm_q;
    sn_d    = sn_q;
    min_d   = min_q;
    pt_d    = pt_q;
    step_d  = step_q;
    vec_d   = vec_q;
    m_d     = m_q;
    unit_d  = unit_q;
    t_d     = t_q;
    nl_d    = nl_q;
    dl_d    = dl_q;
    acc_d   = acc_q;
    sx_d    = sx_q;
    r_d     = r_q;
    len_d   = len_q;
    rem_d   = rem_q;
    dn_d    = dn_q;
    qt_d    = qt_q;
    p_d     = p_q;
    prod_d  = mul_a * mul_b;
    out_d   = out_q;

    if (cmd_i.load) begin
      pt_d[0]  = in_data_i.point_x;
      pt_d[1]  = in_data_i.point_y;
      pt_d[2]  = in_data_i.point_z;
      vec_d[0] = 35'(in_data_i.deriv_x);
      vec_d[1] = 35'(in_data_i.deriv_y);
      vec_d[2] = 35'(in_data_i.deriv_z);
      step_d   = in_data_i.arc_step;
      first_d  = in_data_i.first_sample;
    end

    if (cfg_we_i) begin
      case (cfg_req_i.index)
        rmf_pkg::RegStartNx: sn_d[0] = cfg_req_i.wdata;
        rmf_pkg::RegStartNy: sn_d[1] = cfg_req_i.wdata;
        rmf_pkg::RegStartNz: sn_d[2] = cfg_req_i.wdata;
        rmf_pkg::RegMinSq:   min_d   = cfg_req_i.wdata;
        default: ;
      endcase
    end

    if (cmd_i.go) begin
      op_d = cmd_i.op;
      case (cmd_i.op)
        rmf_pkg::OP_NORM: phase_d = PH_MAG;
        rmf_pkg::OP_SET_T: begin
          t_d    = unit_q;
          done_d = 1'b1;
        end
        rmf_pkg::OP_FIRST: begin
          ppt_d   = pt_q;
          ptan_d  = t_q;
          pnrm_d  = sn_q;
          arc_d   = '0;
          degen_d = 1'b0;
          done_d  = 1'b1;
        end
        rmf_pkg::OP_CHORD: begin
          for (int i = 0; i < 3; i++) vec_d[i] = 35'(pt_q[i]) - 35'(ppt_q[i]);
          arc_d   = arc_sum[32] ? 32'hffff_ffff : arc_sum[31:0];
          degen_d = 1'b0;
          done_d  = 1'b1;
        end
        rmf_pkg::OP_SQ_CHORD, rmf_pkg::OP_SQ_TDIFF,
        rmf_pkg::OP_REFL_N, rmf_pkg::OP_REFL_T, rmf_pkg::OP_REFL_2: begin
          phase_d = (cmd_i.op == rmf_pkg::OP_SQ_CHORD ||
                     cmd_i.op == rmf_pkg::OP_SQ_TDIFF) ? PH_SQL : PH_DOT;
          idx_d   = '0;
          half_d  = 1'b0;
          acc_d   = '0;
        end
        rmf_pkg::OP_DEGEN: begin
          degen_d = 1'b1;
          done_d  = 1'b1;
        end
        rmf_pkg::OP_TDIFF: begin
          for (int i = 0; i < 3; i++) vec_d[i] = 35'(t_q[i]) - 35'(dl_q[i]);
          done_d = 1'b1;
        end
        rmf_pkg::OP_COPY_NL: begin
          pnrm_d = nl_q;
          done_d = 1'b1;
        end
        rmf_pkg::OP_COMMIT: begin
          ppt_d  = pt_q;
          ptan_d = t_q;
          done_d = 1'b1;
        end
        rmf_pkg::OP_OUT: begin
          out_d.normal_x   = pnrm_q[0];
          out_d.normal_y   = pnrm_q[1];
          out_d.normal_z   = pnrm_q[2];
          out_d.tangent_x  = ptan_q[0];
          out_d.tangent_y  = ptan_q[1];
          out_d.tangent_z  = ptan_q[2];
          out_d.arc_total  = arc_q;
          out_d.degenerate = degen_q;
        end
        default: ;
      endcase
    end

    case (phase_q)
      PH_MAG: begin
        for (int i = 0; i < 3; i++) m_d[i] = vec_q[i][34] ? 35'(-vec_q[i]) : 35'(vec_q[i]);
        if (vec_q[0] == '0 && vec_q[1] == '0 && vec_q[2] == '0) begin
          for (int i = 0; i < 3; i++) unit_d[i] = '0;
          done_d  = 1'b1;
          phase_d = PH_IDLE;
        end else begin
          phase_d = PH_SHIFT;
        end
      end
      PH_SHIFT: begin
        // bring the largest magnitude into [2^30, 2^31)
        if (mx[34:31] != '0) begin
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] >> 1;
        end else if (!mx[30]) begin
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] << 1;
        end else begin
          phase_d = PH_SQ;
          idx_d   = '0;
          half_d  = 1'b0;
          acc_d   = '0;
        end
      end
      PH_SQ: begin
        half_d = ~half_q;
        if (half_q) begin
          acc_d = acc_sum;
          if (idx_q == 2'd2) begin
            sx_d    = acc_sum;
            r_d     = '0;
            cnt_d   = '0;
            phase_d = PH_SQRT;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      end
      PH_SQRT: begin
        if (sx_q >= trial) sx_d = sx_q - trial;
        r_d   = r_nx;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          len_d   = r_nx[31:0];
          idx_d   = '0;
          phase_d = PH_DINIT;
        end
      end
      PH_DINIT: begin
        rem_d   = 33'(num[61:32]);
        dn_d    = num[31:0];
        cnt_d   = '0;
        phase_d = PH_DIV;
      end
      PH_DIV: begin
        rem_d = q_bit ? (rem_sh - {1'b0, len_q}) : rem_sh;
        dn_d  = dn_q << 1;
        qt_d  = qfin;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          unit_d[idx_q] = vec_q[idx_q][34] ? -$signed(qfin) : $signed(qfin);
          if (idx_q == 2'd2) begin
            done_d  = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            idx_d   = idx_q + 2'd1;
            phase_d = PH_DINIT;
          end
        end
      end
      PH_SQL: begin
        half_d = ~half_q;
        if (half_q) begin
          acc_d = acc_sum;
          if (idx_q == 2'd2) begin
            below_d = (sq_sh < {32'd0, min_q});
            done_d  = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      end
      PH_DOT: begin
        half_d = ~half_q;
        if (half_q) begin
          acc_d = acc_sum;
          if (idx_q == 2'd2) begin
            p_d     = p_v;
            idx_d   = '0;
            phase_d = PH_RFL;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      end
      PH_RFL: begin
        half_d = ~half_q;
        if (half_q) begin
          case (op_q)
            rmf_pkg::OP_REFL_N: nl_d[idx_q] = rsat;
            rmf_pkg::OP_REFL_T: dl_d[idx_q] = rsat;
            default:            pnrm_d[idx_q] = rsat;
          endcase
          if (idx_q == 2'd2) begin
            done_d  = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
      first_q <= 1'b0;
      below_q <= 1'b0;
      degen_q <= 1'b0;
      arc_q   <= '0;
      idx_q   <= '0;
      half_q  <= 1'b0;
      cnt_q   <= '0;
      op_q    <= rmf_pkg::OP_NORM;
      for (int i = 0; i < 3; i++) begin
        ppt_q[i]  <= '0;
        ptan_q[i] <= '0;
        pnrm_q[i] <= '0;
      end
      sn_q[0] <= '0;
      sn_q[1] <= '0;
      sn_q[2] <= rmf_pkg::StartNzReset;
      min_q   <= rmf_pkg::MinSqReset;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
      first_q <= first_d;
      below_q <= below_d;
      degen_q <= degen_d;
      arc_q   <= arc_d;
      idx_q   <= idx_d;
      half_q  <= half_d;
      cnt_q   <= cnt_d;
      op_q    <= op_d;
      ppt_q   <= ppt_d;
      ptan_q  <= ptan_d;
      pnrm_q  <= pnrm_d;
      sn_q    <= sn_d;
      min_q   <= min_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q   <= pt_d;
    step_q <= step_d;
    vec_q  <= vec_d;
    m_q    <= m_d;
    unit_q <= unit_d;
    t_q    <= t_d;
    nl_q   <= nl_d;
    dl_q   <= dl_d;
    acc_q  <= acc_d;
    sx_q   <= sx_d;
    r_q    <= r_d;
    len_q  <= len_d;
    rem_q  <= rem_d;
    dn_q   <= dn_d;
    qt_q   <= qt_d;
    p_q    <= p_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  assign sts_o.done      = done_q;
  assign sts_o.first     = first_q;
  assign sts_o.below_min = below_q;
  assign out_data_o      = out_q;

endmodule

FILE: rtl/rmf_ctrl.sv
module rmf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rmf_pkg::cmd_t cmd_o,
  input  rmf_pkg::sts_t sts_i
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_NT     = 5'd1;
  localparam logic [4:0] S_SETT   = 5'd2;
  localparam logic [4:0] S_FIRST  = 5'd3;
  localparam logic [4:0] S_CHORD  = 5'd4;
  localparam logic [4:0] S_SQC    = 5'd5;
  localparam logic [4:0] S_DEGEN  = 5'd6;
  localparam logic [4:0] S_NC     = 5'd7;
  localparam logic [4:0] S_RN     = 5'd8;
  localparam logic [4:0] S_RT     = 5'd9;
  localparam logic [4:0] S_TD     = 5'd10;
  localparam logic [4:0] S_SQT    = 5'd11;
  localparam logic [4:0] S_NT2    = 5'd12;
  localparam logic [4:0] S_RN2    = 5'd13;
  localparam logic [4:0] S_CPN    = 5'd14;
  localparam logic [4:0] S_COMMIT = 5'd15;
  localparam logic [4:0] S_OUT    = 5'd16;

  logic [4:0]   state_q, state_d, nxt;
  logic         wait_q, wait_d;
  logic         ovalid_q, ovalid_d;
  rmf_pkg::op_e op;

  always_comb begin
    case (state_q)
      S_NT:     begin op = rmf_pkg::OP_NORM;     nxt = S_SETT; end
      S_SETT:   begin op = rmf_pkg::OP_SET_T;    nxt = sts_i.first ? S_FIRST : S_CHORD; end
      S_FIRST:  begin op = rmf_pkg::OP_FIRST;    nxt = S_OUT; end
      S_CHORD:  begin op = rmf_pkg::OP_CHORD;    nxt = S_SQC; end
      S_SQC:    begin op = rmf_pkg::OP_SQ_CHORD; nxt = sts_i.below_min ? S_DEGEN : S_NC; end
      S_DEGEN:  begin op = rmf_pkg::OP_DEGEN;    nxt = S_OUT; end
      S_NC:     begin op = rmf_pkg::OP_NORM;     nxt = S_RN; end
      S_RN:     begin op = rmf_pkg::OP_REFL_N;   nxt = S_RT; end
      S_RT:     begin op = rmf_pkg::OP_REFL_T;   nxt = S_TD; end
      S_TD:     begin op = rmf_pkg::OP_TDIFF;    nxt = S_SQT; end
      S_SQT:    begin op = rmf_pkg::OP_SQ_TDIFF; nxt = sts_i.below_min ? S_CPN : S_NT2; end
      S_NT2:    begin op = rmf_pkg::OP_NORM;     nxt = S_RN2; end
      S_RN2:    begin op = rmf_pkg::OP_REFL_2;   nxt = S_COMMIT; end
      S_CPN:    begin op = rmf_pkg::OP_COPY_NL;  nxt = S_COMMIT; end
      S_COMMIT: begin op = rmf_pkg::OP_COMMIT;   nxt = S_OUT; end
      S_OUT:    begin op = rmf_pkg::OP_OUT;      nxt = S_IDLE; end
      default:  begin op = rmf_pkg::OP_NORM;     nxt = S_IDLE; end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    wait_d     = wait_q;
    ovalid_d   = ovalid_q;
    cmd_o.load = 1'b0;
    cmd_o.go   = 1'b0;
    cmd_o.op   = op;

    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_NT;
          wait_d     = 1'b0;
        end
      end
      S_OUT: begin
        // result register frees up in the same cycle it is taken
        if (!ovalid_q || out_ready_i) begin
          cmd_o.go = 1'b1;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        if (!wait_q) begin
          cmd_o.go = 1'b1;
          wait_d   = 1'b1;
        end else if (sts_i.done) begin
          wait_d  = 1'b0;
          state_d = nxt;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wait_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wait_q   <= wait_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

endmodule

FILE: rtl/rotation_minimizing_frame_step.sv
// Propagates a rotation-minimizing frame along sampled curve points by double
// reflection, one request at a time. A request is taken only while the block is
// idle. A finished frame sits in an output register, so the next request can be
// taken while that frame still waits downstream. A zero vector skips the shift
// search of a vector normalization and gives a zero unit vector. The search
// needs up to 30 shifts. Most of a full step with both reflections is spent in
// its three vector normalizations. Each runs a shift search, a square-root unit
// and three restoring divisions, all on one shared datapath. The dot products
// and reflections use a single 35x35 multiplier. Configuration writes are always
// accepted and should be issued while idle.
module rotation_minimizing_frame_step (
  input  logic clk_i,
  input  logic rst_ni,
  rmf_in_if.sink    in_i,
  rmf_out_if.source out_o,
  rmf_cfg_if.sink   cfg_i
);

  rmf_pkg::cmd_t cmd;
  rmf_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  rmf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rmf_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_i.data),
    .cfg_we_i   (cfg_i.valid),
    .cfg_req_i  (cfg_i.data),
    .out_data_o (out_o.data)
  );

endmodule

FILE: test/rotation_minimizing_frame_step_checker.sv
module rotation_minimizing_frame_step_checker (
  input  logic clk_i,
  input  logic rst_ni,
  rmf_in_if    in_m,
  rmf_out_if   out_m,
  rmf_cfg_if   cfg_m,
  output int   fail_count_o,
  output int   frames_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint vec3_t [3];

  logic signed [31:0]  start_nrm [3];
  logic [31:0]         min_sq;
  vec3_t               last_pt, last_tan, last_nrm;
  longint unsigned     arc_sum;
  rmf_pkg::out_item_t  frame_q [$];

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // divide by a power of two, rounding half away from zero
  function automatic longint shr_round(longint v, int sh);
    longint unsigned m;
    m = (mag64(v) + (64'd1 << (sh - 1))) >> sh;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic vec3_t unit_vec(vec3_t v);
    longint unsigned m [3];
    longint unsigned mx, ss, len, q;
    vec3_t u;
    mx = 0;
    ss = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag64(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      u = '{0, 0, 0};
      return u;
    end
    while (mx >= (64'd1 << 31)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    for (int i = 0; i < 3; i++) ss += m[i] * m[i];
    len = int_sqrt(ss);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + (len >> 1)) / len;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return u;
  endfunction

  // squares wrap at 64 bits just as the datapath does
  function automatic longint unsigned sq_length(vec3_t d, int sh);
    longint unsigned s, m;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m = mag64(d[i]);
      s += (m * m) >> 2;
    end
    return s >> sh;
  endfunction

  function automatic vec3_t mirror(vec3_t x, vec3_t u);
    longint dot, p, r;
    vec3_t y;
    dot = 0;
    for (int i = 0; i < 3; i++) dot += u[i] * x[i];
    p = shr_round(dot, 30);
    for (int i = 0; i < 3; i++) begin
      r = x[i] - shr_round(u[i] * p, 29);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      y[i] = r;
    end
    return y;
  endfunction

  function automatic rmf_pkg::out_item_t next_frame(rmf_pkg::in_item_t it);
    vec3_t pt, dv, t, v, u, nl, dl;
    logic degen;
    rmf_pkg::out_item_t f;
    degen = 1'b0;
    pt = '{longint'(it.point_x), longint'(it.point_y), longint'(it.point_z)};
    dv = '{longint'(it.deriv_x), longint'(it.deriv_y), longint'(it.deriv_z)};
    t = unit_vec(dv);
    if (it.first_sample) begin
      last_pt = pt;
      last_tan = t;
      for (int i = 0; i < 3; i++) last_nrm[i] = longint'(start_nrm[i]);
      arc_sum = 0;
    end else begin
      arc_sum += it.arc_step;
      if (arc_sum > 64'hFFFF_FFFF) arc_sum = 64'hFFFF_FFFF;
      for (int i = 0; i < 3; i++) v[i] = pt[i] - last_pt[i];
      if (sq_length(v, rmf_pkg::ChordShift) < min_sq) begin
        degen = 1'b1;
      end else begin
        u = unit_vec(v);
        nl = mirror(last_nrm, u);
        dl = mirror(last_tan, u);
        for (int i = 0; i < 3; i++) v[i] = t[i] - dl[i];
        if (sq_length(v, rmf_pkg::TdiffShift) >= min_sq) begin
          u = unit_vec(v);
          last_nrm = mirror(nl, u);
        end else begin
          last_nrm = nl;
        end
        last_pt = pt;
        last_tan = t;
      end
    end
    f.normal_x   = 32'(last_nrm[0]);
    f.normal_y   = 32'(last_nrm[1]);
    f.normal_z   = 32'(last_nrm[2]);
    f.tangent_x  = 32'(last_tan[0]);
    f.tangent_y  = 32'(last_tan[1]);
    f.tangent_z  = 32'(last_tan[2]);
    f.arc_total  = 32'(arc_sum);
    f.degenerate = degen;
    return f;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, got_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rmf_pkg::out_item_t e, g;
    if (!rst_ni) begin
      start_nrm    = '{32'sd0, 32'sd0, rmf_pkg::StartNzReset};
      min_sq       = rmf_pkg::MinSqReset;
      last_pt      = '{0, 0, 0};
      last_tan     = '{0, 0, 0};
      last_nrm     = '{0, 0, 0};
      arc_sum      = 0;
      frame_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_m.valid && out_m.ready) begin
        g = out_m.data;
        if (frame_q.size() == 0) begin
          $error("frame returned with no request outstanding");
          fail_count_o++;
        end else begin
          e = frame_q.pop_front();
          check_field("normal_x", e.normal_x, g.normal_x);
          check_field("normal_y", e.normal_y, g.normal_y);
          check_field("normal_z", e.normal_z, g.normal_z);
          check_field("tangent_x", e.tangent_x, g.tangent_x);
          check_field("tangent_y", e.tangent_y, g.tangent_y);
          check_field("tangent_z", e.tangent_z, g.tangent_z);
          check_field("arc_total", e.arc_total, g.arc_total);
          check_field("degenerate", 32'(e.degenerate), 32'(g.degenerate));
        end
      end
      if (cfg_m.valid && cfg_m.ready) begin
        case (cfg_m.data.index)
          rmf_pkg::RegStartNx: start_nrm[0] = cfg_m.data.wdata;
          rmf_pkg::RegStartNy: start_nrm[1] = cfg_m.data.wdata;
          rmf_pkg::RegStartNz: start_nrm[2] = cfg_m.data.wdata;
          rmf_pkg::RegMinSq:   min_sq = cfg_m.data.wdata;
          default: ;
        endcase
      end
      if (in_m.valid && in_m.ready) frame_q.insert(frame_q.size(), next_frame(in_m.data));
    end
    frames_pending_o = frame_q.size();
  end

endmodule

FILE: test/rotation_minimizing_frame_step_tb.sv
module rotation_minimizing_frame_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, frames_pending;
  int   burst_left = 0;
  int   cyc = 0;
  int   stall_mode = 0;

  rmf_in_if  in_ch ();
  rmf_out_if out_ch ();
  rmf_cfg_if cfg_ch ();

  rotation_minimizing_frame_step dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  rotation_minimizing_frame_step_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_m            (in_ch),
    .out_m           (out_ch),
    .cfg_m           (cfg_ch),
    .fail_count_o    (fail_count),
    .frames_pending_o(frames_pending)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  // receiver stall pattern, picked at random: free-running, random, or mostly stalled
  initial out_ch.ready = 1'b0;
  always @(negedge clk_i) begin
    cyc++;
    if (cyc % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0, 1: out_ch.ready <= 1'b1;
      2: out_ch.ready <= ($urandom_range(0, 1) == 1);
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_sample(rmf_pkg::in_item_t it);
    in_ch.data = it;
    in_ch.valid = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(10, 60) : $urandom_range(0, 4))
        @(negedge clk_i);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_ch.data.index = idx;
    cfg_ch.data.wdata = val;
    cfg_ch.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic wait_all_frames();
    in_ch.valid = 1'b0;
    while (frames_pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic rmf_pkg::in_item_t make_sample(logic fs, logic [31:0] px,
                                                    logic [31:0] py, logic [31:0] pz,
                                                    logic [31:0] dx, logic [31:0] dy,
                                                    logic [31:0] dz, logic [30:0] st);
    rmf_pkg::in_item_t it;
    it.first_sample = fs;
    it.point_x = px;
    it.point_y = py;
    it.point_z = pz;
    it.deriv_x = dx;
    it.deriv_y = dy;
    it.deriv_z = dz;
    it.arc_step = st;
    return it;
  endfunction

  function automatic logic [31:0] jitter(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // well-formed curves with random content, plus noise samples
  task automatic run_curves(int n_samples);
    logic [31:0] p [3];
    logic [31:0] d [3];
    int left;
    rmf_pkg::in_item_t it;
    left = 0;
    for (int k = 0; k < n_samples; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        it = make_sample(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, 31'($urandom));
      end else if (left == 0) begin
        for (int i = 0; i < 3; i++) begin
          p[i] = jitter(1 << 24);
          d[i] = jitter(1 << 22);
        end
        left = $urandom_range(3, 30);
        it = make_sample(1'b1, p[0], p[1], p[2], d[0], d[1], d[2], 31'($urandom));
      end else begin
        for (int i = 0; i < 3; i++) begin
          case ($urandom_range(0, 9))
            0: ;
            1: p[i] += jitter(4);
            default: p[i] += jitter(1 << 20);
          endcase
          if ($urandom_range(0, 4) != 0) d[i] += jitter(1 << 18);
        end
        left--;
        it = make_sample(1'b0, p[0], p[1], p[2], d[0], d[1], d[2],
                         $urandom_range(0, 19) == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 21)));
      end
      send_sample(it);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset settings
    send_sample(make_sample(1'b1, 0, 0, 0, 32'h0001_0000, 0, 0, 31'h7FFF_FFFF));
    send_sample(make_sample(1'b0, 0, 0, 0, 32'h0001_0000, 0, 0, 31'd5));
    // straight line: chord and tangent are parallel
    send_sample(make_sample(1'b0, 32'h0002_0000, 0, 0, 32'h0001_0000, 0, 0, 31'd7));
    send_sample(make_sample(1'b0, 32'h0004_0000, 32'h0001_0000, 0, 0, 32'h0003_0000, 0, 31'd9));
    send_sample(make_sample(1'b0, 32'h0005_0000, 32'h0002_0000, 32'h0001_0000, 0, 0, 0, 31'd1));
    send_sample(make_sample(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF));
    send_sample(make_sample(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
    send_sample(make_sample(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001,
                            32'hFFFF_FFFF, 0, 0, 31'h7FFF_FFFF));
    send_sample(make_sample(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            0, 0, 0, 31'd3));
    send_sample(make_sample(1'b0, 32'h0000_0100, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            0, 32'h0000_0001, 0, 31'd3));
    wait_all_frames();

    // zero chord with zero threshold makes the reflection an identity
    write_reg(rmf_pkg::RegStartNx, 32'h4000_0000);
    write_reg(rmf_pkg::RegStartNy, 32'h0);
    write_reg(rmf_pkg::RegStartNz, 32'h0);
    write_reg(rmf_pkg::RegMinSq, 32'h0);
    send_sample(make_sample(1'b1, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 31'd0));
    send_sample(make_sample(1'b0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 31'd2));
    send_sample(make_sample(1'b0, 32'h0001_0000, 0, 32'h0000_8000, 0, 0, 32'h0001_0000, 31'd2));
    send_sample(make_sample(1'b0, 32'h0001_0000, 0, 32'h0000_8000, 0, 0, 0, 31'd2));
    run_curves(400);
    wait_all_frames();

    // extremes: only a long chord clears the threshold
    write_reg(rmf_pkg::RegStartNx, 32'h8000_0000);
    write_reg(rmf_pkg::RegStartNy, 32'h7FFF_FFFF);
    write_reg(rmf_pkg::RegStartNz, 32'hFFFF_FFFF);
    write_reg(rmf_pkg::RegMinSq, 32'hFFFF_FFFF);
    run_curves(150);
    wait_all_frames();

    write_reg(rmf_pkg::RegStartNx, $urandom);
    write_reg(rmf_pkg::RegStartNy, $urandom);
    write_reg(rmf_pkg::RegStartNz, $urandom);
    write_reg(rmf_pkg::RegMinSq, $urandom_range(0, 4096));
    run_curves(450);
    wait_all_frames();

    write_reg(rmf_pkg::RegStartNx, 32'h0);
    write_reg(rmf_pkg::RegStartNy, 32'hC000_0000);
    write_reg(rmf_pkg::RegStartNz, 32'h0);
    write_reg(rmf_pkg::RegMinSq, 32'h1);
    run_curves(450);
    wait_all_frames();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rmf_pkg.sv
rtl/rmf_if.sv
rtl/rmf_dp.sv
rtl/rmf_ctrl.sv
rtl/rotation_minimizing_frame_step.sv
test/rotation_minimizing_frame_step_checker.sv
test/rotation_minimizing_frame_step_tb.sv
